@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of clk, masked during reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression that must never be true
`define ASSERT_NEVER(label, expr, msg) \
  `ASSERT_CLK(label, !(expr), msg)

`endif

@@ hw/rtl/bir_pkg.sv @@
// ----------------------------------------------------------------------------
// bir_pkg
// Shared constants, register codes and types of the bilinear resizer.
// ----------------------------------------------------------------------------
`default_nettype none

package bir_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int MAX_SRC_W   = 512;
  localparam int MAX_SRC_H   = 64;
  localparam int DEST_LIMIT  = 4096;
  localparam int FRAME_DEPTH = MAX_SRC_W * MAX_SRC_H;
  localparam int ADDR_W      = $clog2(FRAME_DEPTH);
  localparam int SIZE_W      = ADDR_W + 1;
  localparam int COL_W       = $clog2(MAX_SRC_W);
  localparam int ROW_W       = $clog2(MAX_SRC_H);

  localparam int SW_W        = 10;
  localparam int SH_W        = 7;
  localparam int DW_W        = 13;
  localparam int DH_W        = 13;
  localparam int XSTEP_W     = 25;
  localparam int YSTEP_W     = 22;
  localparam int CNT_W       = $clog2(DEST_LIMIT);

  localparam int CH_W        = 8;
  localparam int CHANNELS    = 3;
  localparam int PIX_W       = CH_W * CHANNELS;
  localparam int WGT_W       = FRAC_BITS + 1;
  localparam int ACC_W       = FRAC_BITS + CH_W;

  localparam int APB_AW      = 5;
  localparam int APB_DW      = 32;
  localparam int RIDX_W      = 3;

  localparam logic [RIDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [RIDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [RIDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [RIDX_W-1:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [RIDX_W-1:0] REG_X_STEP     = 3'd4;
  localparam logic [RIDX_W-1:0] REG_Y_STEP     = 3'd5;

  // clamped view of the register file
  typedef struct packed {
    logic [SW_W-1:0]    sw;
    logic [SH_W-1:0]    sh;
    logic [CNT_W-1:0]   dw_m1;
    logic [CNT_W-1:0]   dh_m1;
    logic [XSTEP_W-1:0] x_step;
    logic [YSTEP_W-1:0] y_step;
    logic [SIZE_W-1:0]  frame_size;
  } cfg_t;

  // one request to the shared multiply-accumulate unit
  typedef struct packed {
    logic             en;
    logic             accum;
    logic [WGT_W-1:0] weight;
    logic [CH_W-1:0]  data;
  } mac_req_t;

endpackage

`default_nettype wire

@@ hw/rtl/bilinear_image_resize.sv @@
// ----------------------------------------------------------------------------
// bilinear_image_resize: separable bilinear resize of a BGR frame.
// Load word: written to the frame store on acceptance, next word taken the
// cycle after. Emit word: four frame-store reads on one port, then 18 passes
// of one shared MAC; no word is taken until the result is loaded for output.
// Synchronous active-high reset clears control, counters and positions.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bilinear_image_resize (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // input word
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [23:0]                 s_tdata,  // blue_in, green_in, red_in
  input  wire logic                        s_tuser,  // operation
  // output word
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic      [23:0]                 m_tdata,  // blue_out, green_out, red_out
  output logic                             m_tlast,  // frame_last
  // configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bir_pkg::APB_AW-1:0]  paddr,
  input  wire logic [bir_pkg::APB_DW-1:0]  pwdata,
  output logic      [bir_pkg::APB_DW-1:0]  prdata,
  output logic                             pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_CALC = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [2:0] SUB_TL  = 3'd0;
  localparam logic [2:0] SUB_TR  = 3'd1;
  localparam logic [2:0] SUB_BL  = 3'd2;
  localparam logic [2:0] SUB_BR  = 3'd3;
  localparam logic [2:0] SUB_VT  = 3'd4;
  localparam logic [2:0] SUB_VB  = 3'd5;
  localparam logic [2:0] SUB_SUM = 3'd6;

  localparam logic [2:0] RD_LAST = 3'd4;
  localparam logic [1:0] CH_LAST = 2'(bir_pkg::CHANNELS - 1);
  localparam int XINT_W = bir_pkg::XSTEP_W - bir_pkg::FRAC_BITS;
  localparam int YINT_W = bir_pkg::YSTEP_W - bir_pkg::FRAC_BITS;
  localparam int BASE_W = bir_pkg::ROW_W + bir_pkg::SW_W;

  bir_pkg::cfg_t     cfg;
  bir_pkg::mac_req_t mac_req;
  logic [bir_pkg::ACC_W-1:0] mac_acc;
  logic [bir_pkg::CH_W-1:0]  mac_hi;

  // control
  logic [1:0] state;
  logic [2:0] rd_cnt;
  logic [1:0] chan;
  logic [2:0] sub;
  logic [bir_pkg::ADDR_W-1:0]  load_pos;
  logic [bir_pkg::ADDR_W-1:0]  load_pos_next;
  logic [bir_pkg::CNT_W-1:0]   out_col;
  logic [bir_pkg::CNT_W-1:0]   out_row;
  logic [bir_pkg::XSTEP_W-1:0] x_pos;
  logic [bir_pkg::XSTEP_W-1:0] x_pos_next;
  logic [bir_pkg::YSTEP_W-1:0] y_pos;
  logic [bir_pkg::YSTEP_W-1:0] y_pos_next;

  // payload
  logic [bir_pkg::PIX_W-1:0] pix [4];
  logic [bir_pkg::CH_W-1:0]  top_h;
  logic [bir_pkg::CH_W-1:0]  bot_h;
  logic [bir_pkg::CH_W-1:0]  v1;
  logic [bir_pkg::CH_W-1:0]  res [bir_pkg::CHANNELS];

  logic load_hit;
  logic emit_go;
  logic out_load;
  logic last_col;
  logic last_row;
  logic flat_x;
  logic skip_v;

  logic [bir_pkg::SW_W-1:0]   sw_m1;
  logic [bir_pkg::SH_W-1:0]   sh_m1;
  logic [XINT_W-1:0]          x_int;
  logic [YINT_W-1:0]          y_int;
  logic [bir_pkg::COL_W-1:0]  ix_sat;
  logic [bir_pkg::COL_W-1:0]  col_a;
  logic [bir_pkg::COL_W-1:0]  col_b;
  logic [bir_pkg::ROW_W-1:0]  row_t;
  logic [bir_pkg::ROW_W-1:0]  row_b;
  logic [bir_pkg::ROW_W-1:0]  rd_row;
  logic [bir_pkg::COL_W-1:0]  rd_col;
  logic [BASE_W-1:0]          rd_base;
  logic [BASE_W-1:0]          rd_sum;
  logic [bir_pkg::ADDR_W-1:0] rd_addr;
  logic [bir_pkg::ADDR_W-1:0] wr_addr;
  logic [bir_pkg::SIZE_W-1:0] lp_inc;
  logic [bir_pkg::ADDR_W-1:0] ram_addr;
  logic [bir_pkg::PIX_W-1:0]  ram_rdata;
  logic [1:0]                 pix_idx;

  logic [bir_pkg::FRAC_BITS-1:0] fx;
  logic [bir_pkg::FRAC_BITS-1:0] fy;
  logic [bir_pkg::WGT_W-1:0]     w_one;
  logic [bir_pkg::WGT_W-1:0]     wx_a;
  logic [bir_pkg::WGT_W-1:0]     wx_b;
  logic [bir_pkg::WGT_W-1:0]     wy_top;
  logic [bir_pkg::WGT_W-1:0]     wy_bot;
  logic [bir_pkg::CH_W-1:0]      tl_c;
  logic [bir_pkg::CH_W-1:0]      tr_c;
  logic [bir_pkg::CH_W-1:0]      bl_c;
  logic [bir_pkg::CH_W-1:0]      br_c;

  logic [bir_pkg::XSTEP_W:0] x_sum;
  logic [bir_pkg::YSTEP_W:0] y_sum;

  bir_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign pready = 1'b1;

  bir_ram #(
    .WIDTH (bir_pkg::PIX_W),
    .DEPTH (bir_pkg::FRAME_DEPTH)
  ) u_frame (
    .clk   (clk),
    .we    (load_hit),
    .addr  (ram_addr),
    .wdata (s_tdata),
    .rdata (ram_rdata)
  );

  bir_mac u_mac (
    .clk (clk),
    .req (mac_req),
    .acc (mac_acc)
  );

  assign mac_hi = mac_acc[bir_pkg::ACC_W-1:bir_pkg::FRAC_BITS];

  assign s_tready = (state == ST_IDLE) && !rst;
  assign load_hit = s_tvalid && s_tready && !s_tuser;
  assign emit_go  = s_tvalid && s_tready && s_tuser;
  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  // source coordinates
  assign sw_m1    = cfg.sw - 1'b1;
  assign sh_m1    = cfg.sh - 1'b1;
  assign last_col = out_col >= cfg.dw_m1;
  assign last_row = out_row >= cfg.dh_m1;
  assign flat_x   = last_col || (cfg.sw == bir_pkg::SW_W'(1));
  assign skip_v   = last_row || (cfg.sh == bir_pkg::SH_W'(1));
  assign x_int    = x_pos[bir_pkg::XSTEP_W-1:bir_pkg::FRAC_BITS];
  assign y_int    = y_pos[bir_pkg::YSTEP_W-1:bir_pkg::FRAC_BITS];

  assign ix_sat = (bir_pkg::SW_W'(x_int) >= sw_m1) ? sw_m1[bir_pkg::COL_W-1:0]
                                                   : bir_pkg::COL_W'(x_int);
  assign col_a  = flat_x ? sw_m1[bir_pkg::COL_W-1:0] : ix_sat;
  assign col_b  = (bir_pkg::SW_W'(col_a) >= sw_m1) ? sw_m1[bir_pkg::COL_W-1:0]
                                                   : col_a + 1'b1;
  assign row_t  = (bir_pkg::SH_W'(y_int) >= sh_m1) ? sh_m1[bir_pkg::ROW_W-1:0]
                                                   : bir_pkg::ROW_W'(y_int);
  assign row_b  = (bir_pkg::SH_W'(row_t) >= sh_m1) ? sh_m1[bir_pkg::ROW_W-1:0]
                                                   : row_t + 1'b1;

  // read order: top-left, top-right, bottom-left, bottom-right
  assign rd_row  = rd_cnt[1] ? row_b : row_t;
  assign rd_col  = rd_cnt[0] ? col_b : col_a;
  assign rd_base = BASE_W'(rd_row) * BASE_W'(cfg.sw);
  assign rd_sum  = rd_base + BASE_W'(rd_col);
  assign rd_addr = rd_sum[bir_pkg::ADDR_W-1:0];

  assign wr_addr  = ({1'b0, load_pos} >= cfg.frame_size) ? '0 : load_pos;
  assign lp_inc   = {1'b0, wr_addr} + 1'b1;
  assign load_pos_next = (lp_inc >= cfg.frame_size) ? '0 : lp_inc[bir_pkg::ADDR_W-1:0];
  assign ram_addr = (state == ST_READ) ? rd_addr : wr_addr;
  assign pix_idx  = 2'(rd_cnt - 3'd1);

  // weights
  assign fx     = flat_x ? '0 : x_pos[bir_pkg::FRAC_BITS-1:0];
  assign fy     = y_pos[bir_pkg::FRAC_BITS-1:0];
  assign w_one  = {1'b1, {bir_pkg::FRAC_BITS{1'b0}}};
  assign wx_b   = {1'b0, fx};
  assign wx_a   = w_one - wx_b;
  assign wy_top = w_one - {1'b0, fy};
  assign wy_bot = skip_v ? '0 : {1'b0, fy};

  assign tl_c = pix[0][chan*bir_pkg::CH_W +: bir_pkg::CH_W];
  assign tr_c = pix[1][chan*bir_pkg::CH_W +: bir_pkg::CH_W];
  assign bl_c = pix[2][chan*bir_pkg::CH_W +: bir_pkg::CH_W];
  assign br_c = pix[3][chan*bir_pkg::CH_W +: bir_pkg::CH_W];

  always_comb begin
    mac_req = '0;
    if (state == ST_CALC) begin
      case (sub)
        SUB_TL: begin
          mac_req = '{en: 1'b1, accum: 1'b0, weight: wx_a, data: tl_c};
        end
        SUB_TR: begin
          mac_req = '{en: 1'b1, accum: 1'b1, weight: wx_b, data: tr_c};
        end
        SUB_BL: begin
          mac_req = '{en: 1'b1, accum: 1'b0, weight: wx_a, data: bl_c};
        end
        SUB_BR: begin
          mac_req = '{en: 1'b1, accum: 1'b1, weight: wx_b, data: br_c};
        end
        SUB_VT: begin
          mac_req = '{en: 1'b1, accum: 1'b0, weight: wy_top, data: top_h};
        end
        SUB_VB: begin
          mac_req = '{en: 1'b1, accum: 1'b0, weight: wy_bot, data: bot_h};
        end
        default: mac_req = '0;
      endcase
    end
  end

  // saturating position steps
  assign x_sum = {1'b0, x_pos} + {1'b0, cfg.x_step};
  assign y_sum = {1'b0, y_pos} + {1'b0, cfg.y_step};
  assign x_pos_next = x_sum[bir_pkg::XSTEP_W] ? '1 : x_sum[bir_pkg::XSTEP_W-1:0];
  assign y_pos_next = y_sum[bir_pkg::YSTEP_W] ? '1 : y_sum[bir_pkg::YSTEP_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rd_cnt   <= '0;
      chan     <= '0;
      sub      <= SUB_TL;
      load_pos <= '0;
      out_col  <= '0;
      out_row  <= '0;
      x_pos    <= '0;
      y_pos    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (load_hit) begin
            load_pos <= load_pos_next;
          end
          if (emit_go) begin
            state  <= ST_READ;
            rd_cnt <= '0;
          end
        end
        ST_READ: begin
          if (rd_cnt == RD_LAST) begin
            state <= ST_CALC;
            chan  <= '0;
            sub   <= SUB_TL;
          end else begin
            rd_cnt <= rd_cnt + 1'b1;
          end
        end
        ST_CALC: begin
          if (sub == SUB_SUM) begin
            sub <= SUB_TL;
            if (chan == CH_LAST) begin
              state <= ST_DONE;
            end else begin
              chan <= chan + 1'b1;
            end
          end else begin
            sub <= sub + 1'b1;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
            if (last_col) begin
              out_col <= '0;
              x_pos   <= '0;
              if (last_row) begin
                out_row <= '0;
                y_pos   <= '0;
              end else begin
                out_row <= out_row + 1'b1;
                y_pos   <= y_pos_next;
              end
            end else begin
              out_col <= out_col + 1'b1;
              x_pos   <= x_pos_next;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ && rd_cnt != '0) begin
      pix[pix_idx] <= ram_rdata;
    end
    if (state == ST_CALC) begin
      case (sub)
        SUB_BL:  top_h <= mac_hi;
        SUB_VT:  bot_h <= mac_hi;
        SUB_VB:  v1    <= mac_hi;
        SUB_SUM: res[chan] <= v1 + mac_hi;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {res[2], res[1], res[0]};
      m_tlast <= last_col && last_row;
    end
  end

  `ASSERT_CLK(a_out_from_done, $rose(m_tvalid) |-> ($past(state) == ST_DONE), "word without done")
  `ASSERT_CLK(a_emit_reads, (emit_go) |=> (state == ST_READ && rd_cnt == 3'd0), "emit not read")
  `ASSERT_CLK(a_done_holds, (state == ST_DONE && m_tvalid && !m_tready) |=> (state == ST_DONE && m_tvalid), "stall lost")
  `ASSERT_NEVER(a_chan_range, (state == ST_CALC) && (chan > CH_LAST), "channel overrun")

endmodule

`default_nettype wire

@@ hw/rtl/bir_ram.sv @@
// ----------------------------------------------------------------------------
// bir_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bir_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/bir_mac.sv @@
// ----------------------------------------------------------------------------
// bir_mac
// Shared weight-by-byte multiply-accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none

module bir_mac (
  input  wire logic                    clk,
  input  wire bir_pkg::mac_req_t       req,
  output logic [bir_pkg::ACC_W-1:0]    acc
);

  logic [bir_pkg::WGT_W+bir_pkg::CH_W-1:0] prod;
  logic [bir_pkg::ACC_W-1:0]               base;

  assign prod = {{bir_pkg::CH_W{1'b0}}, req.weight} * {{bir_pkg::WGT_W{1'b0}}, req.data};
  assign base = req.accum ? acc : '0;

  always_ff @(posedge clk) begin
    if (req.en) begin
      acc <= base + prod[bir_pkg::ACC_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bir_regs.sv @@
// ----------------------------------------------------------------------------
// bir_regs
// APB register file with size clamping for the resizer.
// ----------------------------------------------------------------------------
`default_nettype none

module bir_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bir_pkg::APB_AW-1:0]  paddr,
  input  wire logic [bir_pkg::APB_DW-1:0]  pwdata,
  output logic      [bir_pkg::APB_DW-1:0]  prdata,
  output bir_pkg::cfg_t                    cfg
);

  logic [bir_pkg::SW_W-1:0]    src_width;
  logic [bir_pkg::SH_W-1:0]    src_height;
  logic [bir_pkg::DW_W-1:0]    dst_width;
  logic [bir_pkg::DH_W-1:0]    dst_height;
  logic [bir_pkg::XSTEP_W-1:0] x_step;
  logic [bir_pkg::YSTEP_W-1:0] y_step;

  logic [bir_pkg::RIDX_W-1:0]  idx;
  logic                        wr;
  logic [bir_pkg::SW_W-1:0]    sw_c;
  logic [bir_pkg::SH_W-1:0]    sh_c;
  logic [bir_pkg::DW_W-1:0]    dw_c;
  logic [bir_pkg::DH_W-1:0]    dh_c;
  logic [bir_pkg::SW_W+bir_pkg::SH_W-1:0] area;

  assign idx = paddr[bir_pkg::RIDX_W+1:2];
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= bir_pkg::SW_W'(416);
      src_height <= bir_pkg::SH_W'(64);
      dst_width  <= bir_pkg::DW_W'(416);
      dst_height <= bir_pkg::DH_W'(64);
      x_step     <= bir_pkg::XSTEP_W'(1 << bir_pkg::FRAC_BITS);
      y_step     <= bir_pkg::YSTEP_W'(1 << bir_pkg::FRAC_BITS);
    end else if (wr) begin
      case (idx)
        bir_pkg::REG_SRC_WIDTH:  src_width  <= pwdata[bir_pkg::SW_W-1:0];
        bir_pkg::REG_SRC_HEIGHT: src_height <= pwdata[bir_pkg::SH_W-1:0];
        bir_pkg::REG_DST_WIDTH:  dst_width  <= pwdata[bir_pkg::DW_W-1:0];
        bir_pkg::REG_DST_HEIGHT: dst_height <= pwdata[bir_pkg::DH_W-1:0];
        bir_pkg::REG_X_STEP:     x_step     <= pwdata[bir_pkg::XSTEP_W-1:0];
        bir_pkg::REG_Y_STEP:     y_step     <= pwdata[bir_pkg::YSTEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bir_pkg::REG_SRC_WIDTH:  prdata = bir_pkg::APB_DW'(src_width);
      bir_pkg::REG_SRC_HEIGHT: prdata = bir_pkg::APB_DW'(src_height);
      bir_pkg::REG_DST_WIDTH:  prdata = bir_pkg::APB_DW'(dst_width);
      bir_pkg::REG_DST_HEIGHT: prdata = bir_pkg::APB_DW'(dst_height);
      bir_pkg::REG_X_STEP:     prdata = bir_pkg::APB_DW'(x_step);
      bir_pkg::REG_Y_STEP:     prdata = bir_pkg::APB_DW'(y_step);
      default:                 prdata = '0;
    endcase
  end

  // zero counts as one, oversize counts as the maximum
  always_comb begin
    if (src_width == '0) begin
      sw_c = bir_pkg::SW_W'(1);
    end else if (src_width > bir_pkg::SW_W'(bir_pkg::MAX_SRC_W)) begin
      sw_c = bir_pkg::SW_W'(bir_pkg::MAX_SRC_W);
    end else begin
      sw_c = src_width;
    end
    if (src_height == '0) begin
      sh_c = bir_pkg::SH_W'(1);
    end else if (src_height > bir_pkg::SH_W'(bir_pkg::MAX_SRC_H)) begin
      sh_c = bir_pkg::SH_W'(bir_pkg::MAX_SRC_H);
    end else begin
      sh_c = src_height;
    end
    if (dst_width == '0) begin
      dw_c = bir_pkg::DW_W'(1);
    end else if (dst_width > bir_pkg::DW_W'(bir_pkg::DEST_LIMIT)) begin
      dw_c = bir_pkg::DW_W'(bir_pkg::DEST_LIMIT);
    end else begin
      dw_c = dst_width;
    end
    if (dst_height == '0) begin
      dh_c = bir_pkg::DH_W'(1);
    end else if (dst_height > bir_pkg::DH_W'(bir_pkg::DEST_LIMIT)) begin
      dh_c = bir_pkg::DH_W'(bir_pkg::DEST_LIMIT);
    end else begin
      dh_c = dst_height;
    end
  end

  assign area = {{bir_pkg::SH_W{1'b0}}, sw_c} * {{bir_pkg::SW_W{1'b0}}, sh_c};

  always_comb begin
    cfg.sw         = sw_c;
    cfg.sh         = sh_c;
    cfg.dw_m1      = bir_pkg::CNT_W'(dw_c - 1'b1);
    cfg.dh_m1      = bir_pkg::CNT_W'(dh_c - 1'b1);
    cfg.x_step     = x_step;
    cfg.y_step     = y_step;
    cfg.frame_size = area[bir_pkg::SIZE_W-1:0];
  end

endmodule

`default_nettype wire

@@ verif/tb_bilinear_image_resize.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bilinear_image_resize
// Loads small BGR source frames, writes the size and step registers over the
// configuration port and emits resized pixels. A bit-exact predictor of the
// frame store, counters and Q16 positions runs on every accepted input word.
// Each output word is checked against the oldest prediction. Both stream
// sides idle at random.
// ----------------------------------------------------------------------------
module tb_bilinear_image_resize;

  localparam int unsigned ONE_Q    = 1 << bir_pkg::FRAC_BITS;
  localparam int unsigned XPOS_MAX = (1 << bir_pkg::XSTEP_W) - 1;
  localparam int unsigned YPOS_MAX = (1 << bir_pkg::YSTEP_W) - 1;
  localparam int          SETTLE   = 40;
  localparam int          WORD_GOAL = 950;

  typedef enum bit {OP_LOAD = 1'b0, OP_EMIT = 1'b1} op_e;

  typedef struct packed {
    op_e                       op;
    logic [bir_pkg::PIX_W-1:0] pixel;
  } word_t;

  typedef struct packed {
    logic [bir_pkg::PIX_W-1:0] pixel;
    logic                      last;
  } result_t;

  logic                       clk      = 1'b0;
  logic                       rst      = 1'b1;
  logic                       s_tvalid = 1'b0;
  wire                        s_tready;
  logic [23:0]                s_tdata  = '0;  // blue_in, green_in, red_in
  logic                       s_tuser  = 1'b0;  // operation
  wire                        m_tvalid;
  logic                       m_tready = 1'b0;
  wire  [23:0]                m_tdata;  // blue_out, green_out, red_out
  wire                        m_tlast;  // frame_last
  logic                       psel     = 1'b0;
  logic                       penable  = 1'b0;
  logic                       pwrite   = 1'b0;
  logic [bir_pkg::APB_AW-1:0] paddr    = '0;
  logic [bir_pkg::APB_DW-1:0] pwdata   = '0;
  wire  [bir_pkg::APB_DW-1:0] prdata;
  wire                        pready;

  // register copies
  logic [bir_pkg::SW_W-1:0]    cfg_src_w  = 10'd416;
  logic [bir_pkg::SH_W-1:0]    cfg_src_h  = 7'd64;
  logic [bir_pkg::DW_W-1:0]    cfg_dst_w  = 13'd416;
  logic [bir_pkg::DH_W-1:0]    cfg_dst_h  = 13'd64;
  logic [bir_pkg::XSTEP_W-1:0] cfg_x_step = 25'd65536;
  logic [bir_pkg::YSTEP_W-1:0] cfg_y_step = 22'd65536;

  // predictor state
  logic [bir_pkg::PIX_W-1:0] frame_mem [bir_pkg::FRAME_DEPTH];
  int unsigned      load_pos = 0;
  int unsigned      out_col  = 0;
  int unsigned      out_row  = 0;
  int unsigned      x_pos    = 0;
  int unsigned      y_pos    = 0;

  word_t       word_q [$];
  result_t     pixel_expect_q [$];
  word_t       cur_word;
  int          words_left  = 0;
  int          words_taken = 0;
  int          words_made  = 0;
  int          error_count = 0;
  int unsigned filled_size = 0;
  bit          calm;
  string       chan_name [bir_pkg::CHANNELS] = '{"blue_out", "green_out", "red_out"};

  assign calm = (words_taken >= 350) && (words_taken < 600);

  bilinear_image_resize dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned clamp_size(int unsigned v, int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  function automatic int unsigned src_byte(int unsigned row, int unsigned col, int k,
                                           int unsigned sw, int unsigned sh);
    logic [bir_pkg::PIX_W-1:0] px;
    if (row >= sh) row = sh - 1;
    if (col >= sw) col = sw - 1;
    px = frame_mem[row * sw + col];
    return px[8*k +: 8];
  endfunction

  // horizontal blend of one source row, one channel
  function automatic int unsigned blend_row(int unsigned row, int k, bit last_col,
                                            int unsigned sw, int unsigned sh);
    int unsigned      ix;
    int unsigned      f;
    longint unsigned  acc;
    if (last_col || sw == 1) return src_byte(row, sw - 1, k, sw, sh);
    ix = x_pos >> bir_pkg::FRAC_BITS;
    f  = x_pos & (ONE_Q - 1);
    if (ix >= sw) ix = sw - 1;
    acc = longint'(ONE_Q - f) * src_byte(row, ix, k, sw, sh)
        + longint'(f) * src_byte(row, ix + 1, k, sw, sh);
    return 32'((acc >> bir_pkg::FRAC_BITS) & 64'hFF);
  endfunction

  task automatic track_word(word_t w);
    int unsigned sw, sh, dw, dh, size, iy, f, v;
    bit          last_col, last_row;
    int          k;
    result_t     res;
    sw = clamp_size(cfg_src_w, bir_pkg::MAX_SRC_W);
    sh = clamp_size(cfg_src_h, bir_pkg::MAX_SRC_H);
    dw = clamp_size(cfg_dst_w, bir_pkg::DEST_LIMIT);
    dh = clamp_size(cfg_dst_h, bir_pkg::DEST_LIMIT);
    if (w.op == OP_LOAD) begin
      size = sw * sh;
      if (load_pos >= size) load_pos = 0;
      frame_mem[load_pos] = w.pixel;
      load_pos++;
      if (load_pos >= size) load_pos = 0;
    end else begin
      last_col = out_col >= dw - 1;
      last_row = out_row >= dh - 1;
      iy = y_pos >> bir_pkg::FRAC_BITS;
      f  = y_pos & (ONE_Q - 1);
      if (iy >= sh) iy = sh - 1;
      for (k = 0; k < bir_pkg::CHANNELS; k++) begin
        v = 32'((longint'(ONE_Q - f) * blend_row(iy, k, last_col, sw, sh))
                >> bir_pkg::FRAC_BITS);
        if (!last_row && sh != 1)
          v = v + 32'((longint'(f) * blend_row(iy + 1, k, last_col, sw, sh))
                      >> bir_pkg::FRAC_BITS);
        res.pixel[8*k +: 8] = v[7:0];
      end
      res.last = last_col && last_row;
      if (last_col) begin
        out_col = 0;
        x_pos   = 0;
        if (last_row) begin
          out_row = 0;
          y_pos   = 0;
        end else begin
          out_row++;
          y_pos = (longint'(y_pos) + cfg_y_step > YPOS_MAX) ? YPOS_MAX : y_pos + cfg_y_step;
        end
      end else begin
        out_col++;
        x_pos = (longint'(x_pos) + cfg_x_step > XPOS_MAX) ? XPOS_MAX : x_pos + cfg_x_step;
      end
      pixel_expect_q.push_back(res);
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        track_word(cur_word);
        words_left--;
        words_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (word_q.size() > 0 && (calm || $urandom_range(99) >= 15)) begin
          cur_word = word_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= cur_word.pixel;
          s_tuser  <= cur_word.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk) begin : out_monitor
    result_t exp_px;
    int      k;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pixel_expect_q.size() == 0) begin
          $error("output word with no pixel predicted");
          error_count++;
        end else begin
          exp_px = pixel_expect_q.pop_front();
          for (k = 0; k < bir_pkg::CHANNELS; k++)
            if (m_tdata[8*k +: 8] !== exp_px.pixel[8*k +: 8]) begin
              $error("%s expected %0d actual %0d", chan_name[k],
                     exp_px.pixel[8*k +: 8], m_tdata[8*k +: 8]);
              error_count++;
            end
          if (m_tlast !== exp_px.last) begin
            $error("frame_last expected %0d actual %0d", exp_px.last, m_tlast);
            error_count++;
          end
        end
      end
      m_tready <= calm || ($urandom_range(99) >= 15);
    end
  end

  task automatic write_reg(logic [bir_pkg::RIDX_W-1:0] idx,
                           logic [bir_pkg::APB_DW-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      bir_pkg::REG_SRC_WIDTH:  cfg_src_w  = value[bir_pkg::SW_W-1:0];
      bir_pkg::REG_SRC_HEIGHT: cfg_src_h  = value[bir_pkg::SH_W-1:0];
      bir_pkg::REG_DST_WIDTH:  cfg_dst_w  = value[bir_pkg::DW_W-1:0];
      bir_pkg::REG_DST_HEIGHT: cfg_dst_h  = value[bir_pkg::DH_W-1:0];
      bir_pkg::REG_X_STEP:     cfg_x_step = value[bir_pkg::XSTEP_W-1:0];
      bir_pkg::REG_Y_STEP:     cfg_y_step = value[bir_pkg::YSTEP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (words_left != 0 || pixel_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic push_word(op_e op, logic [bir_pkg::PIX_W-1:0] pixel);
    word_t w;
    w.op    = op;
    w.pixel = pixel;
    words_left++;
    words_made++;
    word_q.push_back(w);
  endtask

  function automatic logic [bir_pkg::PIX_W-1:0] rand_pixel();
    logic [bir_pkg::PIX_W-1:0] px;
    int                        k;
    px = bir_pkg::PIX_W'($urandom);
    for (k = 0; k < bir_pkg::CHANNELS; k++)
      case ($urandom_range(7))
        0: px[8*k +: 8] = 8'h00;
        1: px[8*k +: 8] = 8'hFF;
        default: ;
      endcase
    return px;
  endfunction

  // a full run of frame-size loads covers every address below the size
  task automatic fill_frame();
    int unsigned size;
    int unsigned i;
    size = clamp_size(cfg_src_w, bir_pkg::MAX_SRC_W)
         * clamp_size(cfg_src_h, bir_pkg::MAX_SRC_H);
    if (size > filled_size) begin
      for (i = 0; i < size; i++) push_word(OP_LOAD, rand_pixel());
      filled_size = size;
    end
  endtask

  function automatic logic [bir_pkg::APB_DW-1:0] pick_dest();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 8191;
      2:       return $urandom_range(8191);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  function automatic logic [bir_pkg::APB_DW-1:0] pick_step(int unsigned src,
                                                           int unsigned dst,
                                                           int unsigned w);
    case ($urandom_range(5))
      0:       return 0;
      1:       return (1 << w) - 1;
      2:       return $urandom & ((1 << w) - 1);
      default: return (dst > 1) ? ((src - 1) << bir_pkg::FRAC_BITS) / (dst - 1) : 0;
    endcase
  endfunction

  initial begin : stimulus
    int unsigned n, i;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // 2x2 source to 3x3, half-pixel steps, extreme bytes
    write_reg(bir_pkg::REG_SRC_WIDTH, 2);
    write_reg(bir_pkg::REG_SRC_HEIGHT, 2);
    write_reg(bir_pkg::REG_DST_WIDTH, 3);
    write_reg(bir_pkg::REG_DST_HEIGHT, 3);
    write_reg(bir_pkg::REG_X_STEP, 32768);
    write_reg(bir_pkg::REG_Y_STEP, 32768);
    push_word(OP_LOAD, 24'h000000);
    push_word(OP_LOAD, 24'hFFFFFF);
    push_word(OP_LOAD, 24'hFF00FF);
    push_word(OP_LOAD, 24'h80FF7F);
    filled_size = 4;
    for (i = 0; i < 9; i++) push_word(OP_EMIT, '0);
    wait_idle();

    // zero sizes: one-pixel source, one-column output
    write_reg(bir_pkg::REG_SRC_WIDTH, 0);
    write_reg(bir_pkg::REG_SRC_HEIGHT, 0);
    write_reg(bir_pkg::REG_DST_WIDTH, 0);
    write_reg(bir_pkg::REG_DST_HEIGHT, 2);
    write_reg(bir_pkg::REG_X_STEP, 0);
    write_reg(bir_pkg::REG_Y_STEP, 0);
    push_word(OP_LOAD, 24'h3C5AA5);
    for (i = 0; i < 3; i++) push_word(OP_EMIT, '0);
    wait_idle();

    while (words_made < WORD_GOAL) begin
      case ($urandom_range(9))
        0: begin
          write_reg(bir_pkg::REG_SRC_WIDTH, $urandom_range(1) ? 1023 : 512);
          write_reg(bir_pkg::REG_SRC_HEIGHT, $urandom_range(1));
        end
        1: begin
          write_reg(bir_pkg::REG_SRC_WIDTH, $urandom_range(4));
          write_reg(bir_pkg::REG_SRC_HEIGHT, $urandom_range(1) ? 127 : 64);
        end
        default: begin
          write_reg(bir_pkg::REG_SRC_WIDTH, $urandom_range(16));
          write_reg(bir_pkg::REG_SRC_HEIGHT, $urandom_range(8));
        end
      endcase
      if ($urandom_range(3) != 0) write_reg(bir_pkg::REG_DST_WIDTH, pick_dest());
      if ($urandom_range(3) != 0) write_reg(bir_pkg::REG_DST_HEIGHT, pick_dest());
      if ($urandom_range(3) != 0)
        write_reg(bir_pkg::REG_X_STEP,
                  pick_step(clamp_size(cfg_src_w, bir_pkg::MAX_SRC_W),
                            clamp_size(cfg_dst_w, bir_pkg::DEST_LIMIT), bir_pkg::XSTEP_W));
      if ($urandom_range(3) != 0)
        write_reg(bir_pkg::REG_Y_STEP,
                  pick_step(clamp_size(cfg_src_h, bir_pkg::MAX_SRC_H),
                            clamp_size(cfg_dst_h, bir_pkg::DEST_LIMIT), bir_pkg::YSTEP_W));
      fill_frame();
      n = $urandom_range(8, 40);
      for (i = 0; i < n; i++)
        if ($urandom_range(99) < 15) push_word(OP_LOAD, rand_pixel());
        else push_word(OP_EMIT, rand_pixel());
      wait_idle();
    end

    if (error_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/bir_pkg.sv
hw/rtl/bir_ram.sv
hw/rtl/bir_mac.sv
hw/rtl/bir_regs.sv
hw/rtl/bilinear_image_resize.sv
verif/tb_bilinear_image_resize.sv
